[rtl/core/ime_pkg.sv]
// Shared types and constants for the I2C master byte engine.
`timescale 1ns / 1ps

package ime_pkg;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CNT_W      = 16;

  localparam logic [CNT_W-1:0] HALF_PERIOD_RESET = 16'd100;
  localparam logic [CNT_W-1:0] POLL_LIMIT_RESET  = 16'd250;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLL_LIMIT  = 4'd1;

  typedef enum logic [2:0] {
    OP_START    = 3'd0,
    OP_STOP     = 3'd1,
    OP_WRITE    = 3'd2,
    OP_READ     = 3'd3,
    OP_WAIT_ACK = 3'd4
  } op_t;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'd0,
    PH_ST_A    = 5'd1,
    PH_ST_B    = 5'd2,
    PH_ST_C    = 5'd3,
    PH_SP_A    = 5'd4,
    PH_SP_B    = 5'd5,
    PH_SP_C    = 5'd6,
    PH_SP_D    = 5'd7,
    PH_WR_PRE  = 5'd8,
    PH_WR_HIGH = 5'd9,
    PH_WR_LOW  = 5'd10,
    PH_RD_LOW  = 5'd11,
    PH_RD_HIGH = 5'd12,
    PH_AK_LOW  = 5'd13,
    PH_AK_DATA = 5'd14,
    PH_AK_HIGH = 5'd15,
    PH_AK_END  = 5'd16,
    PH_WA_REL  = 5'd17,
    PH_WA_HIGH = 5'd18,
    PH_WA_POLL = 5'd19
  } phase_t;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] operation;
    logic [7:0] write_byte;
    logic       send_ack;
    logic       sda_line;
  } in_item_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_missing;
  } out_item_t;

endpackage

[rtl/core/ime_if.sv]
// Handshake channel interfaces for the I2C master byte engine.
`timescale 1ns / 1ps

interface ime_in_if;
  logic              valid;
  logic              ready;
  ime_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface ime_out_if;
  logic               valid;
  logic               ready;
  ime_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface ime_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ime_pkg::CFG_IDX_W-1:0]    index;
  logic [ime_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/i2c_master_byte_engine.sv]
// I2C master line sequencer: start, stop, byte write, byte read and wait-for-ACK.
`timescale 1ns / 1ps

// Each input item is one timing tick: an optional command plus the sampled SDA
// level. The engine takes one tick per clock cycle and returns one result item
// per tick, registered in the cycle after it is accepted, carrying SCL, the SDA drive value
// and enable, busy, done, the last read byte and the missing-ACK flag. The
// result sits in a single output register; a new tick is accepted whenever that
// register is empty or being taken, so throughput is one tick per cycle unless
// the result side stalls. Every line change is held for half_period_ticks ticks
// (zero acts as one), and a wait-for-ACK that sees SDA high for more than
// ack_poll_limit polls runs a stop sequence and raises ack_missing. Commands
// offered while busy, and unknown operations, are ignored.
module i2c_master_byte_engine (
  input logic           clk,
  input logic           rst_n,
  ime_in_if.sink        in_if,
  ime_out_if.source     out_if,
  ime_cfg_if.sink       cfg_if
);
  import ime_pkg::*;

  logic [CNT_W-1:0] half_r, limit_r;

  phase_t           ph_r, ph_nxt;
  op_t              op_r, op_nxt;
  logic [3:0]       bit_r, bit_nxt;
  logic [CNT_W-1:0] dly_r, dly_nxt;
  logic [CNT_W-1:0] poll_r, poll_nxt;
  logic [7:0]       shift_r, shift_nxt;
  logic             scl_r, scl_nxt;
  logic             sda_r, sda_nxt;
  logic             en_r, en_nxt;
  logic             ackc_r, ackc_nxt;
  logic             tmo_r, tmo_nxt;
  logic [7:0]       held_r, held_nxt;
  logic             done_nxt;

  logic             out_valid_r;
  out_item_t        out_item_r;
  logic             accept;

  in_item_t         it;
  op_t              in_op;
  logic             enter_en, poll_en, finish_en;
  phase_t           enter_ph;
  logic [3:0]       bit_inc;

  assign it        = in_if.payload;
  assign in_op     = op_t'(it.operation);
  assign in_if.ready = !out_valid_r || out_if.ready;
  assign accept    = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;
  assign out_if.valid   = out_valid_r;
  assign out_if.payload = out_item_r;
  assign bit_inc   = bit_r + 4'd1;

  // Next-state sequencing for one tick.
  always_comb begin
    ph_nxt    = ph_r;
    op_nxt    = op_r;
    bit_nxt   = bit_r;
    dly_nxt   = dly_r;
    poll_nxt  = poll_r;
    shift_nxt = shift_r;
    ackc_nxt  = ackc_r;
    tmo_nxt   = tmo_r;
    held_nxt  = held_r;
    enter_en  = 1'b0;
    enter_ph  = PH_IDLE;
    poll_en   = 1'b0;
    finish_en = 1'b0;

    if (ph_r == PH_IDLE) begin
      if (it.cmd_valid && (in_op <= OP_WAIT_ACK)) begin
        op_nxt   = in_op;
        bit_nxt  = 4'd0;
        enter_en = 1'b1;
        unique case (in_op)
          OP_START: enter_ph = PH_ST_A;
          OP_STOP:  enter_ph = PH_SP_A;
          OP_WRITE: begin
            shift_nxt = it.write_byte;
            enter_ph  = PH_WR_PRE;
          end
          OP_READ: begin
            ackc_nxt  = it.send_ack;
            shift_nxt = 8'd0;
            enter_ph  = PH_RD_LOW;
          end
          default: begin
            poll_nxt = '0;
            tmo_nxt  = 1'b0;
            enter_ph = PH_WA_REL;
          end
        endcase
      end
    end else if (ph_r == PH_WA_POLL) begin
      poll_en = 1'b1;
    end else if (dly_r != '0) begin
      dly_nxt = dly_r - 1'b1;
    end else begin
      unique case (ph_r)
        PH_ST_A:    begin enter_en = 1'b1; enter_ph = PH_ST_B;    end
        PH_ST_B:    begin enter_en = 1'b1; enter_ph = PH_ST_C;    end
        PH_SP_A:    begin enter_en = 1'b1; enter_ph = PH_SP_B;    end
        PH_SP_B:    begin enter_en = 1'b1; enter_ph = PH_SP_C;    end
        PH_SP_C:    begin enter_en = 1'b1; enter_ph = PH_SP_D;    end
        PH_WR_PRE:  begin enter_en = 1'b1; enter_ph = PH_WR_HIGH; end
        PH_WR_HIGH: begin enter_en = 1'b1; enter_ph = PH_WR_LOW;  end
        PH_WR_LOW: begin
          bit_nxt = bit_inc;
          if (bit_inc >= 4'd8) begin
            finish_en = 1'b1;
          end else begin
            enter_en = 1'b1;
            enter_ph = PH_WR_PRE;
          end
        end
        PH_RD_LOW:  begin enter_en = 1'b1; enter_ph = PH_RD_HIGH; end
        PH_RD_HIGH: begin
          shift_nxt = {shift_r[6:0], it.sda_line};
          bit_nxt   = bit_inc;
          enter_en  = 1'b1;
          enter_ph  = (bit_inc >= 4'd8) ? PH_AK_LOW : PH_RD_LOW;
        end
        PH_AK_LOW:  begin enter_en = 1'b1; enter_ph = PH_AK_DATA; end
        PH_AK_DATA: begin enter_en = 1'b1; enter_ph = PH_AK_HIGH; end
        PH_AK_HIGH: begin enter_en = 1'b1; enter_ph = PH_AK_END;  end
        PH_AK_END: begin
          held_nxt  = shift_r;
          finish_en = 1'b1;
        end
        PH_WA_REL:  begin enter_en = 1'b1; enter_ph = PH_WA_HIGH; end
        PH_WA_HIGH: poll_en = 1'b1;
        default:    finish_en = 1'b1;
      endcase
    end

    // Acknowledge poll: a low level ends the command, too many highs abort.
    if (poll_en) begin
      ph_nxt = PH_WA_POLL;
      if (!it.sda_line) begin
        tmo_nxt   = 1'b0;
        finish_en = 1'b1;
      end else if (poll_r >= limit_r) begin
        tmo_nxt  = 1'b1;
        enter_en = 1'b1;
        enter_ph = PH_SP_A;
      end else begin
        poll_nxt = poll_r + 1'b1;
      end
    end

    if (enter_en) begin
      ph_nxt  = enter_ph;
      dly_nxt = (half_r == '0) ? '0 : half_r - 1'b1;
      if (enter_ph == PH_WR_HIGH) begin
        shift_nxt = {shift_r[6:0], 1'b0};
      end
    end

    if (finish_en) begin
      ph_nxt  = PH_IDLE;
      dly_nxt = '0;
    end
  end

  // Line levels driven on entry to each phase.
  always_comb begin
    scl_nxt  = scl_r;
    sda_nxt  = sda_r;
    en_nxt   = en_r;
    done_nxt = finish_en;
    if (poll_en && !it.sda_line) begin
      scl_nxt = 1'b0;
    end
    if (enter_en) begin
      unique case (enter_ph)
        PH_ST_A:    begin en_nxt = 1'b1; sda_nxt = 1'b1; scl_nxt = 1'b1; end
        PH_ST_B:    sda_nxt = 1'b0;
        PH_ST_C:    scl_nxt = 1'b0;
        PH_SP_A:    begin en_nxt = 1'b1; scl_nxt = 1'b0; end
        PH_SP_B:    sda_nxt = 1'b0;
        PH_SP_C:    scl_nxt = 1'b1;
        PH_SP_D:    sda_nxt = 1'b1;
        PH_WR_PRE:  begin en_nxt = 1'b1; scl_nxt = 1'b0; end
        PH_WR_HIGH: begin sda_nxt = shift_r[7]; scl_nxt = 1'b1; end
        PH_WR_LOW:  scl_nxt = 1'b0;
        PH_RD_LOW:  begin en_nxt = 1'b0; sda_nxt = 1'b1; scl_nxt = 1'b0; end
        PH_RD_HIGH: scl_nxt = 1'b1;
        PH_AK_LOW:  scl_nxt = 1'b0;
        PH_AK_DATA: begin en_nxt = 1'b1; sda_nxt = !ackc_r; end
        PH_AK_HIGH: scl_nxt = 1'b1;
        PH_AK_END:  scl_nxt = 1'b0;
        PH_WA_REL:  begin en_nxt = 1'b0; sda_nxt = 1'b1; end
        PH_WA_HIGH: scl_nxt = 1'b1;
        default:    scl_nxt = scl_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r  <= HALF_PERIOD_RESET;
      limit_r <= POLL_LIMIT_RESET;
    end else if (cfg_if.valid) begin
      if (cfg_if.index == CFG_HALF_PERIOD) begin
        half_r <= cfg_if.data;
      end else if (cfg_if.index == CFG_POLL_LIMIT) begin
        limit_r <= cfg_if.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r        <= PH_IDLE;
      op_r        <= OP_START;
      bit_r       <= '0;
      dly_r       <= '0;
      poll_r      <= '0;
      shift_r     <= '0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      en_r        <= 1'b1;
      ackc_r      <= 1'b0;
      tmo_r       <= 1'b0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        ph_r    <= ph_nxt;
        op_r    <= op_nxt;
        bit_r   <= bit_nxt;
        dly_r   <= dly_nxt;
        poll_r  <= poll_nxt;
        shift_r <= shift_nxt;
        scl_r   <= scl_nxt;
        sda_r   <= sda_nxt;
        en_r    <= en_nxt;
        ackc_r  <= ackc_nxt;
        tmo_r   <= tmo_nxt;
        held_r  <= held_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item_r.scl         <= scl_nxt;
      out_item_r.sda_out     <= sda_nxt;
      out_item_r.sda_drive   <= en_nxt;
      out_item_r.busy_res    <= (ph_nxt != PH_IDLE);
      out_item_r.done_res    <= done_nxt;
      out_item_r.read_byte   <= held_nxt;
      out_item_r.ack_missing <= tmo_nxt;
    end
  end

  // A completed command leaves the engine idle in the same result.
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.done_res |-> !out_item_r.busy_res)
    else $error("done reported while still busy");

  // SCL stays high for the whole acknowledge poll.
  a_poll_scl_high: assert property (@(posedge clk) disable iff (!rst_n)
    ph_r == PH_WA_POLL |-> scl_r)
    else $error("SCL low during acknowledge poll");

  // A running hold count keeps the phase where it is.
  a_hold_keeps_phase: assert property (@(posedge clk) disable iff (!rst_n)
    accept && ph_r != PH_IDLE && ph_r != PH_WA_POLL && dly_r != '0
    |=> ph_r == $past(ph_r))
    else $error("phase moved during a hold");

  // An idle tick without a usable command stays idle.
  a_idle_stays: assert property (@(posedge clk) disable iff (!rst_n)
    accept && ph_r == PH_IDLE && !(it.cmd_valid && in_op <= OP_WAIT_ACK)
    |=> ph_r == PH_IDLE)
    else $error("engine left idle without a command");

  // A stalled result blocks the next tick.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_if.ready |-> !in_if.ready)
    else $error("tick accepted over a pending result");

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the I2C master byte engine: tick stream in, line levels out.
`timescale 1ns / 1ps

module tb_top;
  import ime_pkg::*;

  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned LONG_HOLD  = 400;

  // Operation codes the engine does not know; they must be ignored.
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  // How the sampled SDA level is chosen for the ticks of one command.
  localparam int SDA_RANDOM = 0;
  localparam int SDA_ONES   = 1;
  localparam int SDA_ZEROS  = 2;

  logic clk = 1'b0;
  logic rst_n;

  ime_in_if  in_ch();
  ime_out_if out_ch();
  ime_cfg_if cfg_ch();

  i2c_master_byte_engine i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Line sequencer state as the engine should hold it.
  phase_t      ph        = PH_IDLE;
  logic [3:0]  bit_idx   = '0;
  logic [15:0] dly       = '0;
  logic [15:0] polls     = '0;
  logic [7:0]  shreg     = '0;
  logic [7:0]  held_rd   = '0;
  logic        scl_q     = 1'b1;
  logic        sda_q     = 1'b1;
  logic        sden_q    = 1'b1;
  logic        ack_sel   = 1'b0;
  logic        ack_lost  = 1'b0;
  logic        done_q    = 1'b0;
  logic [15:0] cfg_half  = HALF_PERIOD_RESET;
  logic [15:0] cfg_limit = POLL_LIMIT_RESET;

  in_item_t  pending_ticks[$];
  out_item_t levels_due[$];

  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned burst_left   = 0;
  int unsigned gap_left     = 0;
  int unsigned hold_left    = 0;
  int unsigned idle_cycles  = 0;
  int unsigned queued       = 0;
  logic [31:0] stall_cnt    = '0;
  int          stall_mode   = 0;
  bit          held_once    = 1'b0;

  function automatic void seq_enter(phase_t p);
    ph  = p;
    dly = (cfg_half == '0) ? '0 : cfg_half - 16'd1;
    case (p)
      PH_ST_A: begin
        sden_q = 1'b1; sda_q = 1'b1; scl_q = 1'b1;
      end
      PH_ST_B:   sda_q = 1'b0;
      PH_ST_C:   scl_q = 1'b0;
      PH_SP_A: begin
        sden_q = 1'b1; scl_q = 1'b0;
      end
      PH_SP_B:   sda_q = 1'b0;
      PH_SP_C:   scl_q = 1'b1;
      PH_SP_D:   sda_q = 1'b1;
      PH_WR_PRE: begin
        sden_q = 1'b1; scl_q = 1'b0;
      end
      PH_WR_HIGH: begin
        sda_q = shreg[7];
        shreg = {shreg[6:0], 1'b0};
        scl_q = 1'b1;
      end
      PH_WR_LOW:  scl_q = 1'b0;
      PH_RD_LOW: begin
        sden_q = 1'b0; sda_q = 1'b1; scl_q = 1'b0;
      end
      PH_RD_HIGH: scl_q = 1'b1;
      PH_AK_LOW:  scl_q = 1'b0;
      PH_AK_DATA: begin
        sden_q = 1'b1; sda_q = !ack_sel;
      end
      PH_AK_HIGH: scl_q = 1'b1;
      PH_AK_END:  scl_q = 1'b0;
      PH_WA_REL: begin
        sden_q = 1'b0; sda_q = 1'b1;
      end
      PH_WA_HIGH: scl_q = 1'b1;
      default: ;
    endcase
  endfunction

  function automatic void seq_finish();
    ph     = PH_IDLE;
    dly    = '0;
    done_q = 1'b1;
  endfunction

  function automatic void seq_poll(logic sda);
    ph = PH_WA_POLL;
    if (!sda) begin
      scl_q    = 1'b0;
      ack_lost = 1'b0;
      seq_finish();
    end else if (polls >= cfg_limit) begin
      // Acknowledge never came: release the bus with a stop sequence.
      ack_lost = 1'b1;
      seq_enter(PH_SP_A);
    end else begin
      polls = polls + 16'd1;
    end
  endfunction

  function automatic void seq_advance(logic sda);
    case (ph)
      PH_ST_A:   seq_enter(PH_ST_B);
      PH_ST_B:   seq_enter(PH_ST_C);
      PH_SP_A:   seq_enter(PH_SP_B);
      PH_SP_B:   seq_enter(PH_SP_C);
      PH_SP_C:   seq_enter(PH_SP_D);
      PH_WR_PRE: seq_enter(PH_WR_HIGH);
      PH_WR_HIGH: seq_enter(PH_WR_LOW);
      PH_WR_LOW: begin
        bit_idx = bit_idx + 4'd1;
        if (bit_idx >= 4'd8) seq_finish();
        else seq_enter(PH_WR_PRE);
      end
      PH_RD_LOW: seq_enter(PH_RD_HIGH);
      PH_RD_HIGH: begin
        shreg   = {shreg[6:0], sda};
        bit_idx = bit_idx + 4'd1;
        if (bit_idx >= 4'd8) seq_enter(PH_AK_LOW);
        else seq_enter(PH_RD_LOW);
      end
      PH_AK_LOW:  seq_enter(PH_AK_DATA);
      PH_AK_DATA: seq_enter(PH_AK_HIGH);
      PH_AK_HIGH: seq_enter(PH_AK_END);
      PH_AK_END: begin
        held_rd = shreg;
        seq_finish();
      end
      PH_WA_REL:  seq_enter(PH_WA_HIGH);
      PH_WA_HIGH: seq_poll(sda);
      default:    seq_finish();
    endcase
  endfunction

  function automatic out_item_t predict_tick(in_item_t t);
    out_item_t r;
    done_q = 1'b0;
    if (ph == PH_IDLE) begin
      if (t.cmd_valid && t.operation <= OP_WAIT_ACK) begin
        bit_idx = '0;
        case (op_t'(t.operation))
          OP_START: seq_enter(PH_ST_A);
          OP_STOP:  seq_enter(PH_SP_A);
          OP_WRITE: begin
            shreg = t.write_byte;
            seq_enter(PH_WR_PRE);
          end
          OP_READ: begin
            ack_sel = t.send_ack;
            shreg   = '0;
            seq_enter(PH_RD_LOW);
          end
          default: begin
            polls    = '0;
            ack_lost = 1'b0;
            seq_enter(PH_WA_REL);
          end
        endcase
      end
    end else if (ph == PH_WA_POLL) begin
      seq_poll(t.sda_line);
    end else if (dly != '0) begin
      dly = dly - 16'd1;
    end else begin
      seq_advance(t.sda_line);
    end
    r.scl         = scl_q;
    r.sda_out     = sda_q;
    r.sda_drive   = sden_q;
    r.busy_res    = (ph != PH_IDLE);
    r.done_res    = done_q;
    r.read_byte   = held_rd;
    r.ack_missing = ack_lost;
    return r;
  endfunction

  function automatic void push_tick(bit v, logic [2:0] op, logic [7:0] wb, bit sa, bit sda);
    in_item_t t;
    t.cmd_valid  = v;
    t.operation  = op;
    t.write_byte = wb;
    t.send_ack   = sa;
    t.sda_line   = sda;
    pending_ticks.push_back(t);
    queued++;
  endfunction

  // Ticks for an idle engine: no command, or only codes it must ignore.
  function automatic void push_idle(int unsigned n);
    bit         v;
    logic [2:0] op;
    repeat (n) begin
      v  = 1'($urandom);
      op = v ? 3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO)) : 3'($urandom);
      push_tick(v, op, 8'($urandom), 1'($urandom), 1'($urandom));
    end
  endfunction

  // One command followed by exactly the ticks it needs to complete. The
  // filler ticks carry random commands, which a busy engine must ignore.
  function automatic void push_cmd(op_t op, logic [7:0] wb, bit sa, int unsigned hi_polls,
                                   int sda_mode);
    int unsigned h;
    int unsigned len;
    int unsigned first_poll;
    bit          sda;
    h          = (cfg_half == '0) ? 1 : cfg_half;
    first_poll = 2 * h;
    case (op)
      OP_START: len = 3 * h;
      OP_STOP:  len = 4 * h;
      OP_WRITE: len = 24 * h;
      OP_READ:  len = 20 * h;
      default:  len = (hi_polls > cfg_limit) ? first_poll + cfg_limit + 4 * h
                                             : first_poll + hi_polls;
    endcase
    push_tick(1'b1, op, wb, sa, 1'($urandom));
    for (int unsigned j = 1; j <= len; j++) begin
      case (sda_mode)
        SDA_ONES:  sda = 1'b1;
        SDA_ZEROS: sda = 1'b0;
        default:   sda = 1'($urandom);
      endcase
      if (op == OP_WAIT_ACK && j >= first_poll && j - first_poll <= hi_polls)
        sda = (j - first_poll < hi_polls);
      push_tick($urandom_range(0, 3) == 0, 3'($urandom), 8'($urandom), 1'($urandom), sda);
    end
  endfunction

  task automatic wait_drained();
    @(negedge clk);
    while (pending_ticks.size() != 0 || in_ch.valid || levels_due.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == CFG_HALF_PERIOD) cfg_half = val;
    else if (idx == CFG_POLL_LIMIT) cfg_limit = val;
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic void check_field(string fname, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 40)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
    end
  endfunction

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin : drive_ticks
    bit       taken;
    bit       offer;
    in_item_t nxt;
    taken = in_ch.valid && in_ch.ready;
    offer = in_ch.valid && !taken;
    nxt   = in_ch.payload;
    if (!rst_n) begin
      offer = 1'b0;
    end else begin
      if (taken) levels_due.push_back(predict_tick(in_ch.payload));
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_ticks.size() > 0) begin
          nxt   = pending_ticks.pop_front();
          offer = 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end
      end
    end
    in_ch.valid   <= offer;
    in_ch.payload <= nxt;
  end

  // Receiver: checks each item and stalls on a pattern that is chosen at random.
  always @(posedge clk) begin : take_levels
    out_item_t want;
    out_item_t got;
    bit        rdy;
    rdy = 1'b0;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.payload;
        results_seen++;
        if (levels_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 40)
            $display("%0t: item with nothing outstanding, expected none, actual %0h",
                     $time, got);
        end else begin
          want = levels_due.pop_front();
          check_field("scl", 8'(want.scl), 8'(got.scl));
          check_field("sda_out", 8'(want.sda_out), 8'(got.sda_out));
          check_field("sda_drive", 8'(want.sda_drive), 8'(got.sda_drive));
          check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
          check_field("done_res", 8'(want.done_res), 8'(got.done_res));
          check_field("read_byte", want.read_byte, got.read_byte);
          check_field("ack_missing", 8'(want.ack_missing), 8'(got.ack_missing));
        end
      end
      stall_cnt = stall_cnt + 1;
      if (stall_cnt[5:0] == '0) stall_mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
      end else if (!held_once && results_seen >= 1200) begin
        // One long hold-off so that the engine fills up and stops taking ticks.
        held_once = 1'b1;
        hold_left = LONG_HOLD - 1;
      end else begin
        case (stall_mode)
          0:       rdy = 1'b1;
          1:       rdy = ($urandom_range(0, 3) != 0);
          2:       rdy = stall_cnt[0];
          default: rdy = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
    out_ch.ready <= rdy;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned start;
    int unsigned hi;
    int          pick;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.payload  = '0;
    out_ch.ready   = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = '0;
    cfg_ch.data    = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values of both registers in use.
    push_cmd(OP_START, 8'h00, 1'b0, 0, SDA_RANDOM);
    wait_drained();

    // Zero half period acts as one tick; zero poll limit fails on the first high poll.
    write_reg(CFG_HALF_PERIOD, 16'h0000);
    write_reg(CFG_POLL_LIMIT, 16'h0000);
    for (int op = OP_UNUSED_LO; op <= OP_UNUSED_HI; op++)
      push_tick(1'b1, 3'(op), 8'hFF, 1'b1, 1'b1);
    push_cmd(OP_START, 8'h00, 1'b0, 0, SDA_RANDOM);
    push_cmd(OP_WRITE, 8'hFF, 1'b1, 0, SDA_RANDOM);
    push_cmd(OP_WRITE, 8'h00, 1'b0, 0, SDA_RANDOM);
    push_cmd(OP_READ, 8'hFF, 1'b1, 0, SDA_ONES);
    push_cmd(OP_READ, 8'h00, 1'b0, 0, SDA_ZEROS);
    push_cmd(OP_WAIT_ACK, 8'h00, 1'b0, 0, SDA_RANDOM);
    push_cmd(OP_WAIT_ACK, 8'hFF, 1'b1, 1, SDA_RANDOM);
    // A plain stop must leave the missing-ACK flag as it was.
    push_cmd(OP_STOP, 8'h00, 1'b0, 0, SDA_RANDOM);
    push_cmd(OP_WAIT_ACK, 8'h00, 1'b0, 0, SDA_RANDOM);
    wait_drained();

    write_reg(CFG_HALF_PERIOD, 16'd2);
    write_reg(CFG_POLL_LIMIT, 16'd1);
    push_cmd(OP_WAIT_ACK, 8'h00, 1'b0, 1, SDA_RANDOM);
    push_cmd(OP_WAIT_ACK, 8'h00, 1'b0, 2, SDA_RANDOM);
    push_cmd(OP_WRITE, 8'hA5, 1'b0, 0, SDA_RANDOM);
    push_cmd(OP_READ, 8'h00, 1'b1, 0, SDA_RANDOM);
    push_cmd(OP_STOP, 8'h00, 1'b0, 0, SDA_RANDOM);
    wait_drained();

    // A long hold, then a shorter half period written while the start is under way.
    write_reg(CFG_HALF_PERIOD, 16'd100);
    push_tick(1'b1, OP_START, 8'h00, 1'b0, 1'b1);
    push_idle(5);
    wait_drained();
    write_reg(CFG_HALF_PERIOD, 16'd1);
    push_idle(100);
    wait_drained();

    write_reg(CFG_POLL_LIMIT, 16'hFFFF);
    push_cmd(OP_WAIT_ACK, 8'h00, 1'b0, 200, SDA_RANDOM);
    wait_drained();

    repeat (4) begin
      pick = $urandom_range(0, 4);
      write_reg(CFG_HALF_PERIOD, (pick == 0) ? 16'd0 : (pick <= 2) ? 16'd1 : 16'(pick - 1));
      write_reg(CFG_POLL_LIMIT, 16'($urandom_range(0, 6)));
      start = queued;
      while (queued - start < 215) begin
        if ($urandom_range(0, 99) < 8) begin
          // Raw ticks: may cut a command short or start one out of step.
          repeat ($urandom_range(1, 20))
            push_tick(1'($urandom), 3'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
        end else begin
          hi = ($urandom_range(0, 2) == 0) ? cfg_limit + 1 : $urandom_range(0, cfg_limit);
          push_cmd(op_t'($urandom_range(OP_START, OP_WAIT_ACK)), 8'($urandom),
                   1'($urandom), hi, SDA_RANDOM);
          push_idle($urandom_range(0, 2));
        end
      end
      wait_drained();
    end

    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
